@@ rtl/aes_pkg.sv @@
// Shared types, codes and round functions for the AES-128 core.
// No dependencies; imported by aes_ctrl, aes_dpath and aes128_block_cipher.
`default_nettype none
package aes_pkg;

  // Request and result payloads
  typedef struct packed {
    logic [1:0]  op;
    logic [5:0]  index;
    logic [31:0] data_word;
  } aes_in_t;

  typedef struct packed {
    logic [31:0] result_word;
    logic [1:0]  word_pos;
    logic        last;
  } aes_out_t;

  // Operation codes
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_ENC  = 2'd1;
  localparam logic [1:0] OP_DEC  = 2'd2;

  localparam int unsigned NUM_KEY_WORDS = 44;
  localparam int unsigned NUM_ROUNDS    = 10;
  localparam int unsigned KEY_ROWS      = NUM_ROUNDS + 1;
  localparam int unsigned ROW_W         = $clog2(KEY_ROWS);

  // Controller to datapath commands
  typedef struct packed {
    logic             key_wr;
    logic             buf_wr;
    logic             load_block;
    logic             step;
    logic             first;
    logic             dec;
    logic             mix;
    logic [ROW_W-1:0] key_row;
    logic [1:0]       out_pos;
  } aes_cmd_t;

  localparam logic [7:0] FWD_BOX [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  localparam logic [7:0] INV_BOX [256] = '{
    8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
    8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
    8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
    8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
    8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
    8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
    8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
    8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
    8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
    8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
    8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
    8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
    8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
    8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
    8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
  };

  // Multiply by x in GF(2^8)
  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Substitute all sixteen bytes
  function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    for (int i = 0; i < 16; i++) begin
      t[8*i +: 8] = inv ? INV_BOX[s[8*i +: 8]] : FWD_BOX[s[8*i +: 8]];
    end
    sub_bytes = t;
  endfunction

  // Rotate row r left by r columns, or right when inv is set
  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[8*(4*c+r) +: 8] = inv ? s[8*(4*((c+3*r)%4)+r) +: 8]
                                : s[8*(4*((c+r)%4)+r) +: 8];
      end
    end
    shift_rows = t;
  endfunction

  // Forward or inverse column mix
  function automatic logic [127:0] mix_cols(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    logic [7:0]   a [4];
    logic [7:0]   a2 [4];
    logic [7:0]   a4 [4];
    logic [7:0]   a8 [4];
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        a[j]  = s[8*(4*c+j) +: 8];
        a2[j] = xtime(a[j]);
        a4[j] = xtime(a2[j]);
        a8[j] = xtime(a4[j]);
      end
      for (int r = 0; r < 4; r++) begin
        if (inv) begin
          t[8*(4*c+r) +: 8] = (a8[r] ^ a4[r] ^ a2[r])
                            ^ (a8[(r+1)%4] ^ a2[(r+1)%4] ^ a[(r+1)%4])
                            ^ (a8[(r+2)%4] ^ a4[(r+2)%4] ^ a[(r+2)%4])
                            ^ (a8[(r+3)%4] ^ a[(r+3)%4]);
        end else begin
          t[8*(4*c+r) +: 8] = a2[r] ^ (a2[(r+1)%4] ^ a[(r+1)%4])
                            ^ a[(r+2)%4] ^ a[(r+3)%4];
        end
      end
    end
    mix_cols = t;
  endfunction

endpackage
`default_nettype wire

@@ rtl/aes_ctrl.sv @@
// Sequencer for the AES-128 core: request decode, round count, result drain.
// Depends on aes_pkg; drives aes_dpath through aes_cmd_t.
`default_nettype none
module aes_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire aes_pkg::aes_in_t in_req,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  out_last,
  output aes_pkg::aes_cmd_t     cmd
);
  import aes_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(NUM_ROUNDS);

  logic [1:0]       state_r, state_nxt;
  logic [ROW_W-1:0] rnd_r, rnd_nxt;
  logic             dir_r, dir_nxt;
  logic [1:0]       pos_r, pos_nxt;
  logic             accept, is_data, start, req_dec;
  logic [ROW_W-1:0] rnd_inc;

  // Decode the incoming request
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign is_data  = (in_req.op == OP_ENC) || (in_req.op == OP_DEC);
  assign req_dec  = (in_req.op == OP_DEC);
  assign start    = accept && is_data && (in_req.index == 6'd3);
  assign rnd_inc  = rnd_r + 1'b1;

  assign out_valid = (state_r == ST_OUT);
  assign out_last  = (pos_r == 2'd3);

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    rnd_nxt   = rnd_r;
    dir_nxt   = dir_r;
    pos_nxt   = pos_r;

    cmd            = '0;
    cmd.key_wr     = accept && (in_req.op == OP_LOAD)
                     && (in_req.index < 6'(NUM_KEY_WORDS));
    cmd.buf_wr     = accept && is_data && (in_req.index < 6'd3);
    cmd.load_block = start;
    cmd.first      = (rnd_r == '0);
    cmd.dec        = dir_r;
    cmd.mix        = (rnd_r != '0) && (rnd_r != LAST_ROW);
    cmd.out_pos    = pos_r;

    unique case (state_r)
      ST_IDLE: begin
        // Fetch the first round key together with the block
        cmd.key_row = (start && req_dec) ? LAST_ROW : '0;
        if (start) begin
          state_nxt = ST_RUN;
          rnd_nxt   = '0;
          dir_nxt   = req_dec;
        end
      end
      ST_RUN: begin
        // Apply one round and prefetch the next key row
        cmd.step = 1'b1;
        if (rnd_r != LAST_ROW) begin
          cmd.key_row = dir_r ? (LAST_ROW - rnd_inc) : rnd_inc;
        end
        rnd_nxt = rnd_inc;
        if (rnd_r == LAST_ROW) begin
          state_nxt = ST_OUT;
          pos_nxt   = 2'd0;
        end
      end
      ST_OUT: begin
        // Drain four result words
        if (!out_stall) begin
          pos_nxt = pos_r + 2'd1;
          if (pos_r == 2'd3) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rnd_r   <= '0;
      dir_r   <= 1'b0;
      pos_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
      dir_r   <= dir_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/aes_dpath.sv @@
// Datapath for the AES-128 core: round-key memory, word buffer, round unit.
// Depends on aes_pkg; commanded by aes_ctrl.
`default_nettype none
module aes_dpath (
  input  wire logic              clk,
  input  wire aes_pkg::aes_in_t  in_req,
  input  wire aes_pkg::aes_cmd_t cmd,
  output logic [31:0]            result_word
);
  import aes_pkg::*;

  logic [127:0] key_mem [KEY_ROWS];
  logic [127:0] key_q_r;
  logic [31:0]  buf_r [3];
  logic [127:0] state_r, state_nxt;
  logic [127:0] pre, mixed, keyed;

  // Write one key word into its row lane; read a whole row each cycle
  always_ff @(posedge clk) begin
    if (cmd.key_wr) begin
      key_mem[in_req.index[5:2]][32*in_req.index[1:0] +: 32] <= in_req.data_word;
    end
    key_q_r <= key_mem[cmd.key_row];
  end

  // Hold the first three words of a block
  always_ff @(posedge clk) begin
    if (cmd.buf_wr) begin
      buf_r[in_req.index[1:0]] <= in_req.data_word;
    end
  end

  // One round: substitute and shift, then mix and add key (encrypt) or add key and unmix (decrypt)
  always_comb begin
    pre   = cmd.first ? state_r : sub_bytes(shift_rows(state_r, cmd.dec), cmd.dec);
    mixed = cmd.mix ? mix_cols(pre, 1'b0) : pre;
    keyed = pre ^ key_q_r;
    if (cmd.dec) begin
      state_nxt = cmd.mix ? mix_cols(keyed, 1'b1) : keyed;
    end else begin
      state_nxt = mixed ^ key_q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_block) begin
      state_r <= {in_req.data_word, buf_r[2], buf_r[1], buf_r[0]};
    end else if (cmd.step) begin
      state_r <= state_nxt;
    end
  end

  assign result_word = state_r[32*cmd.out_pos +: 32];

endmodule
`default_nettype wire

@@ rtl/aes128_block_cipher.sv @@
// AES-128 encrypt/decrypt core with loaded round keys: top level.
// Depends on aes_pkg, aes_ctrl and aes_dpath.
//
// Usage: send requests on in_valid/in_req. op load writes round-key word
// index (0..43); encrypt/decrypt requests carry block words 0..3. Words 0..2
// are held; word 3 starts the block in the direction of its own op.
// Loads and held words are taken whenever the core is idle.
// After word 3 the core runs eleven round steps, one per cycle, limited by
// the single round unit and the one-row-per-cycle key memory read; the four
// result words then leave on out_valid/out_rsp in order, last on word 3.
// out_valid rises once the last round step has been applied.
// in_stall is high while a block is computing or draining.
// When out_stall is high the current result word holds until taken.
// Reset clears the sequencer; keys and held words are unknown until written.
`default_nettype none
module aes128_block_cipher (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire aes_pkg::aes_in_t  in_req,
  output logic                   in_stall,
  output logic                   out_valid,
  output aes_pkg::aes_out_t      out_rsp,
  input  wire logic              out_stall
);
  import aes_pkg::*;

  aes_cmd_t    cmd;
  logic        last;
  logic [31:0] word;

  aes_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_req    (in_req),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_last  (last),
    .cmd       (cmd)
  );

  aes_dpath u_dpath (
    .clk         (clk),
    .in_req      (in_req),
    .cmd         (cmd),
    .result_word (word)
  );

  // Assemble the result request
  assign out_rsp.result_word = word;
  assign out_rsp.word_pos    = cmd.out_pos;
  assign out_rsp.last        = last;

endmodule
`default_nettype wire

@@ verif/aes128_block_cipher_tb.sv @@
// Testbench for the AES-128 encrypt/decrypt core: directed and random requests,
// results checked against an in-bench cipher model. Depends on aes_pkg and the RTL.
`default_nettype none
module aes128_block_cipher_tb;
  import aes_pkg::*;

  // Tracks expected result words and counts mismatches
  class cipher_scoreboard;
    logic [31:0] key_words [44];
    logic [31:0] held_words [3];
    aes_out_t    pending [$];
    int          errors;

    function new();
      errors = 0;
    endfunction

    function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] k);
      logic [7:0] acc;
      acc = 8'h00;
      while (k != 0) begin
        if (k[0]) acc = acc ^ a;
        a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        k = k >> 1;
      end
      return acc;
    endfunction

    function automatic void xor_round(ref logic [7:0] s [16], input int rnd);
      for (int w = 0; w < 4; w++)
        for (int b = 0; b < 4; b++)
          s[4*w+b] = s[4*w+b] ^ key_words[rnd*4+w][8*b +: 8];
    endfunction

    function automatic void substitute(ref logic [7:0] s [16], input bit inv);
      for (int i = 0; i < 16; i++) s[i] = inv ? INV_BOX[s[i]] : FWD_BOX[s[i]];
    endfunction

    function automatic void rotate_rows(ref logic [7:0] s [16], input int dir);
      logic [7:0] t [16];
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) t[4*c+r] = s[4*((c + r*dir) % 4) + r];
      s = t;
    endfunction

    function automatic void mix(ref logic [7:0] s [16], input bit inv);
      logic [7:0] coef [4];
      logic [7:0] col [4];
      logic [7:0] v;
      if (inv) coef = '{8'd14, 8'd11, 8'd13, 8'd9};
      else coef = '{8'd2, 8'd3, 8'd1, 8'd1};
      for (int c = 0; c < 4; c++) begin
        for (int j = 0; j < 4; j++) col[j] = s[4*c+j];
        for (int r = 0; r < 4; r++) begin
          v = 8'h00;
          for (int j = 0; j < 4; j++) v = v ^ gmul(col[j], coef[(j+4-r) % 4]);
          s[4*c+r] = v;
        end
      end
    endfunction

    // Note an accepted request and queue any result words it causes
    function automatic void note_request(aes_in_t rq);
      logic [7:0] s [16];
      logic [31:0] words [4];
      aes_out_t e;
      if (rq.op == OP_LOAD) begin
        if (rq.index < 44) key_words[rq.index] = rq.data_word;
        return;
      end
      if (rq.op != OP_ENC && rq.op != OP_DEC) return;
      if (rq.index > 3) return;
      if (rq.index < 3) begin
        held_words[rq.index] = rq.data_word;
        return;
      end
      for (int w = 0; w < 3; w++) words[w] = held_words[w];
      words[3] = rq.data_word;
      for (int w = 0; w < 4; w++)
        for (int b = 0; b < 4; b++) s[4*w+b] = words[w][8*b +: 8];
      if (rq.op == OP_ENC) begin
        xor_round(s, 0);
        for (int r = 1; r <= 9; r++) begin
          substitute(s, 0); rotate_rows(s, 1); mix(s, 0); xor_round(s, r);
        end
        substitute(s, 0); rotate_rows(s, 1); xor_round(s, 10);
      end else begin
        xor_round(s, 10); rotate_rows(s, 3); substitute(s, 1);
        for (int r = 9; r >= 1; r--) begin
          xor_round(s, r); mix(s, 1); rotate_rows(s, 3); substitute(s, 1);
        end
        xor_round(s, 0);
      end
      for (int w = 0; w < 4; w++) begin
        for (int b = 0; b < 4; b++) e.result_word[8*b +: 8] = s[4*w+b];
        e.word_pos = w[1:0];
        e.last = (w == 3);
        pending.push_back(e);
      end
    endfunction

    // Compare one result word with the oldest expectation
    task automatic check_result(aes_out_t got);
      aes_out_t e;
      if (pending.size() == 0) begin
        report("result with nothing pending", 0, got.result_word);
        return;
      end
      e = pending.pop_front();
      if (got.result_word !== e.result_word)
        report("result_word", e.result_word, got.result_word);
      if (got.word_pos !== e.word_pos) report("word_pos", e.word_pos, got.word_pos);
      if (got.last !== e.last) report("last", e.last, got.last);
    endtask

    task automatic report(string what, logic [31:0] exp_v, logic [31:0] got_v);
      $display("mismatch %s: expected %h got %h", what, exp_v, got_v);
      errors++;
    endtask
  endclass

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  aes_in_t  in_req;
  logic     in_stall;
  logic     out_valid;
  aes_out_t out_rsp;
  logic     out_stall;

  cipher_scoreboard sb;
  int  idle_cycles;
  bit  stim_done;
  bit  hold_off;
  bit  hold_done;
  int  sent;

  aes128_block_cipher uut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_req(in_req), .in_stall(in_stall),
    .out_valid(out_valid), .out_rsp(out_rsp), .out_stall(out_stall)
  );

  always #5 clk = ~clk;

  // Monitor both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (in_valid && !in_stall) sb.note_request(in_req);
      if (out_valid && !out_stall) sb.check_result(out_rsp);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (idle_cycles > 3000) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver stall pattern, with one long hold-off
  initial begin
    int phase;
    out_stall = 1'b0;
    phase = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        for (int i = 0; i < 200; i++) @(negedge clk);
        hold_off = 0;
        hold_done = 1;
        out_stall <= 1'b0;
      end else begin
        phase++;
        if ((phase / 64) % 3 == 0) out_stall <= 1'b0;
        else if ((phase / 64) % 3 == 1) out_stall <= ($urandom_range(0, 3) == 0);
        else out_stall <= ($urandom_range(0, 1) == 0);
      end
    end
  end

  // Offer one request and hold it until taken
  task automatic send_request(logic [1:0] op, logic [5:0] index, logic [31:0] word);
    in_valid <= 1'b1;
    in_req <= '{op: op, index: index, data_word: word};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  // Drop valid for a random gap, now and then
  task automatic maybe_gap();
    int gap;
    if ($urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      for (int i = 0; i < gap; i++) @(negedge clk);
    end
  endtask

  task automatic send_block(logic [1:0] dir, logic [31:0] w0, logic [31:0] w1,
                            logic [31:0] w2, logic [31:0] w3);
    send_request(($urandom_range(0, 1) ? OP_ENC : OP_DEC), 6'd0, w0); maybe_gap();
    send_request(($urandom_range(0, 1) ? OP_ENC : OP_DEC), 6'd1, w1); maybe_gap();
    send_request(($urandom_range(0, 1) ? OP_ENC : OP_DEC), 6'd2, w2); maybe_gap();
    send_request(dir, 6'd3, w3); maybe_gap();
  endtask

  task automatic load_keys(bit all_ones);
    for (int i = 0; i < 44; i++)
      send_request(OP_LOAD, i[5:0], all_ones ? 32'hFFFF_FFFF : $urandom());
  endtask

  initial begin
    int kind;
    sb = new();
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req = '0;
    idle_cycles = 0;
    stim_done = 0;
    hold_off = 0;
    hold_done = 0;
    sent = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extreme keys and data, both directions, ignored requests
    load_keys(1);
    send_block(OP_ENC, 32'h0, 32'h0, 32'h0, 32'h0);
    send_block(OP_DEC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_LOAD, 6'd63, 32'h1234_5678);
    send_request(OP_ENC, 6'd63, 32'hDEAD_BEEF);
    send_request(2'd3, 6'd3, 32'hCAFE_F00D);
    load_keys(0);
    send_block(OP_ENC, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);

    // Long receiver hold-off while requests keep coming
    hold_off = 1;
    while (!hold_done) send_block(OP_ENC, $urandom(), $urandom(), $urandom(), $urandom());

    // Random: mostly well-formed blocks, some key reloads and noise
    while (sent < 230) begin
      kind = $urandom_range(0, 19);
      if (kind < 14)
        send_block($urandom_range(0, 1) ? OP_ENC : OP_DEC,
                   $urandom(), $urandom(), $urandom(), $urandom());
      else if (kind < 17)
        send_request(OP_LOAD, 6'($urandom_range(0, 43)), $urandom());
      else if (kind < 18)
        send_request(OP_LOAD, 6'($urandom_range(44, 63)), $urandom());
      else if (kind < 19)
        send_request(2'($urandom_range(1, 2)), 6'($urandom_range(4, 63)), $urandom());
      else
        send_request(2'd3, 6'($urandom_range(0, 63)), $urandom());
      maybe_gap();
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then settle
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
`default_nettype wire
